/* sv/ref_pkg.sv */
// Package for the row edge finder: field widths, column arithmetic types and
// the state word carried through the binary search stages.
// No dependencies.
package ref_pkg;

  localparam int PIX_LOW_W  = 64;
  localparam int PIX_MID_W  = 64;
  localparam int PIX_HIGH_W = 32;
  localparam int PIX_EXT_W  = 192;
  localparam int START_W    = 8;
  localparam int EDGE_W     = 8;
  localparam int COL_W      = 10;
  localparam int SUM_W      = COL_W + 1;
  // A search span never exceeds 2**START_W, so this many halvings always finish.
  localparam int BIS_STEPS  = START_W;

  typedef logic signed [COL_W-1:0] col_t;

  typedef struct packed {
    col_t a;
    col_t b;
  } bis_t;

endpackage

/* sv/row_edge_finder_unit.sv */
// Row edge finder top level: coarse probe search and pipelined binary search
// for the left and right track edges of one binarized camera row.
// Depends on ref_pkg.

// One word enters per clock cycle when the output side keeps up. The accepting
// edge registers the row and the start residue in stage 1. Stage 2 marks the
// black probe columns, and the probe pick stage after it picks the innermost
// black probe on each side. One further stage follows for each halving step of
// the two binary searches. A stall at the output holds the pipeline, and empty
// stages still fill while it waits.
module row_edge_finder_unit import ref_pkg::*; #(
  parameter int ROW_WIDTH   = 160,
  parameter int COARSE_STEP = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_LOW_W-1:0]  pixels_low,
  input  logic [PIX_MID_W-1:0]  pixels_mid,
  input  logic [PIX_HIGH_W-1:0] pixels_high,
  input  logic [START_W-1:0]    start_column,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [EDGE_W-1:0]     left_edge,
  output logic [EDGE_W-1:0]     right_edge
);

  localparam int IDX_W       = $clog2(ROW_WIDTH);
  localparam int RES_W       = $clog2(COARSE_STEP);
  localparam int RIGHT_LIMIT = ROW_WIDTH - 1 - COARSE_STEP;
  localparam int RL_RES      = RIGHT_LIMIT % COARSE_STEP;
  localparam int N           = BIS_STEPS;

  typedef logic [ROW_WIDTH-1:0] row_t;

  function automatic bis_t bis_step(input bis_t s, input row_t row);
    logic signed [SUM_W-1:0] diff;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] half;
    col_t m;
    logic black;
    bis_t n;
    diff = SUM_W'(s.a) - SUM_W'(s.b);
    sum  = SUM_W'(s.a) + SUM_W'(s.b);
    // Halve with truncation toward zero.
    half = (sum + $signed({{(SUM_W-1){1'b0}}, sum[SUM_W-1]})) >>> 1;
    m = half[COL_W-1:0];
    black = 1'b0;
    if (!m[COL_W-1] && (m < col_t'(ROW_WIDTH))) begin
      black = row[m[IDX_W-1:0]];
    end
    n = s;
    if (!(diff == '0 || diff == SUM_W'(1) || diff == {SUM_W{1'b1}})) begin
      if (black) begin
        n.b = m;
      end else begin
        n.a = m;
      end
    end
    return n;
  endfunction

  logic [RES_W-1:0] mod_tbl [0:(2**START_W)-1];

  for (genvar v = 0; v < 2**START_W; v++) begin : g_mod
    assign mod_tbl[v] = RES_W'(v % COARSE_STEP);
  end

  logic [PIX_EXT_W-1:0] pix_ext;
  assign pix_ext = {{(PIX_EXT_W-PIX_HIGH_W-PIX_MID_W-PIX_LOW_W){1'b0}},
                    pixels_high, pixels_mid, pixels_low};

  // Stage 1: row, start and start residue.
  logic               vld1;
  row_t               row1;
  logic [START_W-1:0] start1;
  logic [RES_W-1:0]   res1;

  // Stage 2: black probe columns and fallback search bounds.
  logic vld2;
  row_t row2;
  row_t lhit2;
  row_t rhit2;
  col_t lfa2;
  col_t rfa2;

  // Binary search stages; index 0 is the probe pick result.
  logic [N:0] bvld;
  logic [N:0] bgo;
  row_t       brow [0:N-1];
  bis_t       bl   [0:N];
  bis_t       br   [0:N];

  logic go1;
  logic go2;

  assign bgo[N]   = !bvld[N] || out_ready;
  assign go2      = !vld2 || bgo[0];
  assign go1      = !vld1 || go2;
  assign in_ready = go1;

  row_t lprobe;
  row_t rprobe;
  col_t start_col;
  col_t lfin;
  col_t rfin;
  col_t roff;
  col_t res_col;

  for (genvar c = 0; c < ROW_WIDTH; c++) begin : g_probe
    assign lprobe[c] = (c > COARSE_STEP) && ({1'b0, start1} >= (START_W+1)'(c)) &&
                       (res1 == RES_W'(c % COARSE_STEP));
    assign rprobe[c] = (c < RIGHT_LIMIT) && ({1'b0, start1} <= (START_W+1)'(c)) &&
                       (res1 == RES_W'(c % COARSE_STEP));
  end

  always_comb begin
    start_col = COL_W'(start1);
    res_col   = COL_W'(res1);
    if (start_col <= col_t'(COARSE_STEP)) begin
      lfin = start_col;
    end else if (res1 == '0) begin
      lfin = col_t'(COARSE_STEP);
    end else begin
      lfin = res_col;
    end
    if (res_col >= col_t'(RL_RES)) begin
      roff = res_col - col_t'(RL_RES);
    end else begin
      roff = res_col + col_t'(COARSE_STEP - RL_RES);
    end
    if (start_col >= col_t'(RIGHT_LIMIT)) begin
      rfin = start_col;
    end else begin
      rfin = col_t'(RIGHT_LIMIT) + roff;
    end
  end

  logic             lfound;
  logic             rfound;
  logic [IDX_W-1:0] lpos;
  logic [IDX_W-1:0] rpos;
  bis_t             lsel;
  bis_t             rsel;
  col_t             lpos_col;
  col_t             rpos_col;

  always_comb begin
    lfound = 1'b0;
    lpos   = '0;
    for (int c = 0; c < ROW_WIDTH; c++) begin
      if (lhit2[c]) begin
        lfound = 1'b1;
        lpos   = IDX_W'(c);
      end
    end
    rfound = 1'b0;
    rpos   = '0;
    for (int c = ROW_WIDTH - 1; c >= 0; c--) begin
      if (rhit2[c]) begin
        rfound = 1'b1;
        rpos   = IDX_W'(c);
      end
    end
    lpos_col = COL_W'(lpos);
    rpos_col = COL_W'(rpos);
    if (lfound) begin
      lsel.a = lpos_col + col_t'(COARSE_STEP - 1);
      lsel.b = lpos_col;
    end else begin
      lsel.a = lfa2;
      lsel.b = '0;
    end
    if (rfound) begin
      rsel.a = rpos_col - col_t'(COARSE_STEP - 1);
      rsel.b = rpos_col;
    end else begin
      rsel.a = rfa2;
      rsel.b = col_t'(ROW_WIDTH - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      bvld[0] <= 1'b0;
    end else begin
      if (go1) begin
        vld1 <= in_valid;
      end
      if (go2) begin
        vld2 <= vld1;
      end
      if (bgo[0]) begin
        bvld[0] <= vld2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      row1   <= pix_ext[ROW_WIDTH-1:0];
      start1 <= start_column;
      res1   <= mod_tbl[start_column];
    end
    if (go2) begin
      row2  <= row1;
      lhit2 <= row1 & lprobe;
      rhit2 <= row1 & rprobe;
      lfa2  <= lfin + col_t'(COARSE_STEP);
      rfa2  <= rfin - col_t'(COARSE_STEP);
    end
    if (bgo[0]) begin
      brow[0] <= row2;
      bl[0]   <= lsel;
      br[0]   <= rsel;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_bis
    assign bgo[k] = !bvld[k] || bgo[k+1];
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        bvld[k+1] <= 1'b0;
      end else if (bgo[k+1]) begin
        bvld[k+1] <= bvld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (bgo[k+1]) begin
        bl[k+1] <= bis_step(bl[k], brow[k]);
        br[k+1] <= bis_step(br[k], brow[k]);
      end
    end

    if (k < N - 1) begin : g_row
      always_ff @(posedge clk) begin
        if (bgo[k+1]) begin
          brow[k+1] <= brow[k];
        end
      end
    end
  end

  assign out_valid  = bvld[N];
  assign left_edge  = bl[N].b[EDGE_W-1:0];
  assign right_edge = br[N].b[EDGE_W-1:0];

endmodule

/* test/testbench.sv */
// Testbench for row_edge_finder_unit: a queued driver and a monitor check every edge pair
// against an edge search predictor kept here, under random sender bursts and receiver stalls.
// Depends on ref_pkg and row_edge_finder_unit.
module testbench;
  import ref_pkg::*;

  localparam int ROW_COLS = 160;
  localparam int PROBE_STEP = 8;
  localparam int RANDOM_ROWS = 1200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;
  localparam bit [ROW_COLS-1:0] ALL_BLACK = {ROW_COLS{1'b1}};

  typedef struct {
    bit [ROW_COLS-1:0] row;
    bit [START_W-1:0] start;
    bit drain_first;
  } row_word_t;

  typedef struct packed {
    logic [EDGE_W-1:0] left_col;
    logic [EDGE_W-1:0] right_col;
  } track_edges_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PATTERN} ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PIX_LOW_W-1:0] pixels_low = '0;
  logic [PIX_MID_W-1:0] pixels_mid = '0;
  logic [PIX_HIGH_W-1:0] pixels_high = '0;
  logic [START_W-1:0] start_column = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [EDGE_W-1:0] left_edge;
  logic [EDGE_W-1:0] right_edge;

  row_word_t pending_rows[$];
  track_edges_t expected_edges[$];
  int total_rows = 0;
  int rows_accepted = 0;
  int pairs_checked = 0;
  int left_lost = 0;
  int right_lost = 0;
  int errors = 0;
  int idle_cycles = 0;
  bit in_taken = 1'b0;
  int gap_left = 0;
  int burst_left = 1;
  ready_mode_t ready_mode = READY_ALWAYS;
  int ready_span = 0;
  int ready_phase = 0;
  bit [7:0] ready_pattern = 8'b1011_0010;

  row_edge_finder_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixels_low(pixels_low),
    .pixels_mid(pixels_mid),
    .pixels_high(pixels_high),
    .start_column(start_column),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .left_edge(left_edge),
    .right_edge(right_edge)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit column_black(input bit [ROW_COLS-1:0] row, input int col);
    if (col < 0 || col >= ROW_COLS) return 1'b0;
    return row[col];
  endfunction

  function automatic int narrow_edge(input bit [ROW_COLS-1:0] row, input int a, input int b);
    int mid;
    while (a != b && a - b != 1 && b - a != 1) begin
      mid = (a + b) / 2;
      if (column_black(row, mid)) b = mid;
      else a = mid;
    end
    return b;
  endfunction

  function automatic track_edges_t predict_edges(input bit [ROW_COLS-1:0] row,
                                                 input bit [START_W-1:0] start);
    track_edges_t found_edges;
    int probe;
    int col;
    bit hit;
    probe = start;
    hit = 1'b0;
    col = 0;
    while (!hit && probe > PROBE_STEP) begin
      if (column_black(row, probe)) begin
        col = narrow_edge(row, probe + PROBE_STEP - 1, probe);
        hit = 1'b1;
      end else begin
        probe -= PROBE_STEP;
      end
    end
    if (!hit) col = narrow_edge(row, probe + PROBE_STEP, 0);
    found_edges.left_col = col[EDGE_W-1:0];
    probe = start;
    hit = 1'b0;
    while (!hit && probe < ROW_COLS - 1 - PROBE_STEP) begin
      if (column_black(row, probe)) begin
        col = narrow_edge(row, probe - (PROBE_STEP - 1), probe);
        hit = 1'b1;
      end else begin
        probe += PROBE_STEP;
      end
    end
    if (!hit) col = narrow_edge(row, probe - PROBE_STEP, ROW_COLS - 1);
    found_edges.right_col = col[EDGE_W-1:0];
    return found_edges;
  endfunction

  function automatic bit [ROW_COLS-1:0] track_row(input int left_end, input int right_begin,
                                                  input int noise);
    bit [ROW_COLS-1:0] row;
    row = '0;
    for (int c = 0; c < ROW_COLS; c++) begin
      if (c < left_end || c >= right_begin) row[c] = 1'b1;
    end
    repeat (noise) row[$urandom_range(0, ROW_COLS - 1)] ^= 1'b1;
    return row;
  endfunction

  task automatic add_row(input bit [ROW_COLS-1:0] row, input int start, input bit drain_first);
    row_word_t word;
    word.row = row;
    word.start = start[START_W-1:0];
    word.drain_first = drain_first;
    pending_rows.push_back(word);
    total_rows++;
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      expected_edges.push_back(predict_edges({pixels_high, pixels_mid, pixels_low},
                                             start_column));
      rows_accepted++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    row_word_t word;
    bit present;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      present = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_rows.size() > 0 &&
                   !(pending_rows[0].drain_first && expected_edges.size() != 0)) begin
        word = pending_rows.pop_front();
        pixels_low <= word.row[PIX_LOW_W-1:0];
        pixels_mid <= word.row[PIX_LOW_W+PIX_MID_W-1:PIX_LOW_W];
        pixels_high <= word.row[ROW_COLS-1:PIX_LOW_W+PIX_MID_W];
        start_column <= word.start;
        present = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 7) == 0) begin
          burst_left = $urandom_range(40, 80);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      in_valid <= present;
    end
  end

  always @(negedge clk) begin
    bit ready;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (ready_span == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        ready_span = $urandom_range(8, 64);
      end
      ready_span--;
      case (ready_mode)
        READY_ALWAYS: ready = 1'b1;
        READY_COIN: ready = $urandom_range(0, 1);
        READY_SPARSE: ready = ($urandom_range(0, 3) == 0);
        default: begin
          ready = ready_pattern[ready_phase];
          ready_phase = (ready_phase + 1) % 8;
        end
      endcase
      out_ready <= ready;
    end
  end

  always @(posedge clk) begin
    track_edges_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_edges.size() == 0) begin
        $display("%0t: unexpected word left_edge %0d right_edge %0d", $time, left_edge,
                 right_edge);
        errors++;
      end else begin
        want = expected_edges.pop_front();
        pairs_checked++;
        if (want.left_col == 0) left_lost++;
        if (want.right_col == ROW_COLS - 1) right_lost++;
        if (left_edge !== want.left_col) begin
          $display("%0t: left_edge expected %0d actual %0d", $time, want.left_col, left_edge);
          errors++;
        end
        if (right_edge !== want.right_col) begin
          $display("%0t: right_edge expected %0d actual %0d", $time, want.right_col,
                   right_edge);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : stimulus
    bit [ROW_COLS-1:0] row;
    bit [ROW_COLS-1:0] one_hot;
    int kind;
    int left_end;
    int right_begin;
    int start;
    add_row('0, 80, 1'b0);
    add_row(ALL_BLACK, 80, 1'b0);
    add_row('0, 0, 1'b0);
    add_row(ALL_BLACK, 0, 1'b0);
    add_row('0, 159, 1'b0);
    add_row(ALL_BLACK, 159, 1'b0);
    add_row('0, 167, 1'b0);
    add_row(ALL_BLACK, 167, 1'b0);
    add_row('0, 255, 1'b0);
    add_row(ALL_BLACK, 255, 1'b0);
    add_row({$urandom, $urandom, $urandom, $urandom, $urandom}, 160, 1'b0);
    add_row(track_row(40, 120, 0), 80, 1'b0);
    add_row(ALL_BLACK, 8, 1'b0);
    add_row(ALL_BLACK, 9, 1'b0);
    add_row(ALL_BLACK, 151, 1'b0);
    one_hot = '0;
    one_hot[159] = 1'b1;
    add_row(one_hot, 150, 1'b0);
    one_hot = '0;
    one_hot[0] = 1'b1;
    add_row(one_hot, 4, 1'b0);
    one_hot = '0;
    one_hot[63] = 1'b1;
    add_row(one_hot, 100, 1'b0);
    one_hot = '0;
    one_hot[64] = 1'b1;
    add_row(one_hot, 30, 1'b0);
    one_hot = '0;
    one_hot[127] = 1'b1;
    add_row(one_hot, 140, 1'b0);
    one_hot = '0;
    one_hot[128] = 1'b1;
    add_row(one_hot, 100, 1'b0);
    add_row({(ROW_COLS / 4){4'b0101}}, 77, 1'b0);
    add_row({(ROW_COLS / 4){4'b1010}}, 78, 1'b0);

    for (int i = 0; i < RANDOM_ROWS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        left_end = $urandom_range(0, 70);
        right_begin = $urandom_range(90, ROW_COLS);
        row = track_row(left_end, right_begin, $urandom_range(0, 3));
        start = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ROW_COLS - 1)
                                            : $urandom_range(left_end, right_begin - 1);
      end else if (kind < 75) begin
        row = {$urandom, $urandom, $urandom, $urandom, $urandom};
        start = $urandom_range(0, ROW_COLS - 1);
      end else if (kind < 85) begin
        row = {$urandom, $urandom, $urandom, $urandom, $urandom} &
              {$urandom, $urandom, $urandom, $urandom, $urandom} &
              {$urandom, $urandom, $urandom, $urandom, $urandom};
        start = $urandom_range(0, ROW_COLS - 1);
      end else if (kind < 90) begin
        row = $urandom_range(0, 1) ? ALL_BLACK : '0;
        row[$urandom_range(0, ROW_COLS - 1)] ^= 1'b1;
        start = $urandom_range(0, ROW_COLS - 1);
      end else begin
        row = $urandom_range(0, 1) ? {$urandom, $urandom, $urandom, $urandom, $urandom}
                                   : track_row($urandom_range(0, 70),
                                               $urandom_range(90, ROW_COLS), 1);
        start = $urandom_range(ROW_COLS, 255);
      end
      add_row(row, start, (i % 400) == 0);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (!(rows_accepted == total_rows && expected_edges.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
    end
    if (idle_cycles < WATCHDOG_LIMIT) repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d rows and checked %0d edge pairs, %0d with the left edge lost", rows_accepted,
             pairs_checked, left_lost);
    $display("and %0d with the right edge lost; %0d mismatches found.", right_lost, errors);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", expected_edges.size());
      $display("row_edge_finder_unit regression: fail");
    end else if (errors == 0 && expected_edges.size() == 0) begin
      $display("row_edge_finder_unit regression: pass");
    end else begin
      $display("row_edge_finder_unit regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
sv/ref_pkg.sv
sv/row_edge_finder_unit.sv
test/testbench.sv
